### hdl/msiva_pkg.sv
// Types and constants shared by the MSI vector allocator.
`default_nettype none

package msiva_pkg;

   localparam int NUM_VECTORS = 256;
   localparam int VEC_W       = 8;
   localparam int WORD_W      = 64;
   localparam int NUM_WORDS   = NUM_VECTORS / WORD_W;
   localparam int WORD_IDX_W  = 2;
   localparam int BIT_IDX_W   = 6;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_FULL       = 2'd1;
   localparam status_type ST_NOT_IN_USE = 2'd2;

   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   localparam logic MAP_LINEAR  = 1'b0;
   localparam logic MAP_SCATTER = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

### hdl/msi_vector_allocator.sv
// MSI vector allocator: first-free allocation over a bitmap held in a small memory.
//
// A request word on the req_ channel either allocates the lowest free vector or releases
// the named one; each request yields exactly one response word on the rsp_ channel with a
// status, the vector and its interrupt line and bit under the current mapping mode.
// The in-use bitmap lives in a four-row memory of 64-bit words with a registered read.
// The first row read is issued in the accepting cycle. An allocation reads rows in turn
// until one has a free bit or the last row is read; a release reads only the named
// vector's row. Each result passes from the registered row read into a pending register
// and then into the response register. A new request is accepted in the cycle after the
// previous response is registered, so requests do not overlap.
// A response waits in the output register while rsp_ready is low; the block still
// accepts and processes the next request, holding its result until the register frees.
// Reset marks every row invalid, which reads as all vectors free, so no clearing pass
// is needed, and sets the mapping mode to linear. The mode register is written through
// csr_wr_en and csr_wr_data; the user must do so only while the block is idle (not enforced).
`default_nettype none

module msi_vector_allocator (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire                       req_type,
   input  wire  [7:0]                req_vector,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output msiva_pkg::status_type     rsp_status,
   output logic [7:0]                rsp_vector_out,
   output logic [1:0]                rsp_line,
   output logic [5:0]                rsp_line_bit,
   input  wire                       csr_wr_en,
   input  wire                       csr_wr_data
);

   import msiva_pkg::*;

   logic [WORD_W-1:0]     mem [NUM_WORDS];
   logic [WORD_W-1:0]     rd_data_ff;
   logic [NUM_WORDS-1:0]  row_valid_ff;

   state_type             state_ff, state_in;
   logic                  op_type_ff;
   logic [VEC_W-1:0]      op_vec_ff;
   logic [WORD_IDX_W-1:0] idx_ff, idx_in;
   logic                  mapping_mode_ff;

   status_type            pend_status_ff, pend_status_in;
   logic [VEC_W-1:0]      pend_vec_ff, pend_vec_in;
   logic                  pend_load;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [VEC_W-1:0]      rsp_vec_ff;
   logic [1:0]            rsp_line_ff;
   logic [5:0]            rsp_bit_ff;
   logic                  rsp_load;

   logic [WORD_IDX_W-1:0] rd_addr;
   logic                  wr_en;
   logic [WORD_W-1:0]     wr_data;
   logic                  accept;

   logic [WORD_W-1:0]     word_cur;
   logic                  has_free;
   logic [BIT_IDX_W-1:0]  free_pos;
   logic [BIT_IDX_W-1:0]  rel_bit;

   function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [WORD_W-1:0] w);
      logic [BIT_IDX_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) begin
            pos = BIT_IDX_W'(i);
         end
      end
      return pos;
   endfunction

   assign accept   = req_valid && req_ready;
   assign word_cur = row_valid_ff[idx_ff] ? rd_data_ff : '0;
   assign has_free = ~(&word_cur);
   assign free_pos = first_zero(word_cur);
   assign rel_bit  = op_vec_ff[BIT_IDX_W-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (op_type_ff == REQ_RELEASE || has_free ||
                idx_ff == WORD_IDX_W'(NUM_WORDS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      req_ready      = 1'b0;
      rd_addr        = idx_ff;
      idx_in         = idx_ff;
      wr_en          = 1'b0;
      wr_data        = word_cur;
      pend_load      = 1'b0;
      pend_status_in = ST_OK;
      pend_vec_in    = op_vec_ff;
      rsp_load       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = (req_type == REQ_ALLOC) ? '0 : req_vector[VEC_W-1 -: WORD_IDX_W];
            idx_in    = rd_addr;
         end
         S_LOOK: begin
            if (op_type_ff == REQ_RELEASE) begin
               wr_en          = 1'b1;
               wr_data        = word_cur & ~(WORD_W'(1) << rel_bit);
               pend_load      = 1'b1;
               pend_status_in = word_cur[rel_bit] ? ST_OK : ST_NOT_IN_USE;
               pend_vec_in    = op_vec_ff;
            end else if (has_free) begin
               wr_en          = 1'b1;
               wr_data        = word_cur | (WORD_W'(1) << free_pos);
               pend_load      = 1'b1;
               pend_status_in = ST_OK;
               pend_vec_in    = {idx_ff, free_pos};
            end else if (idx_ff == WORD_IDX_W'(NUM_WORDS - 1)) begin
               pend_load      = 1'b1;
               pend_status_in = ST_FULL;
               pend_vec_in    = '0;
            end else begin
               rd_addr = idx_ff + WORD_IDX_W'(1);
               idx_in  = rd_addr;
            end
         end
         S_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         row_valid_ff    <= '0;
         mapping_mode_ff <= MAP_LINEAR;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            row_valid_ff[idx_ff] <= 1'b1;
         end
         if (csr_wr_en) begin
            mapping_mode_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept) begin
         op_type_ff <= req_type;
         op_vec_ff  <= req_vector;
      end
      if (pend_load) begin
         pend_status_ff <= pend_status_in;
         pend_vec_ff    <= pend_vec_in;
      end
      if (rsp_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_vec_ff    <= pend_vec_ff;
         if (mapping_mode_ff == MAP_SCATTER) begin
            rsp_line_ff <= pend_vec_ff[1:0];
            rsp_bit_ff  <= pend_vec_ff[7:2];
         end else begin
            rsp_line_ff <= pend_vec_ff[7:6];
            rsp_bit_ff  <= pend_vec_ff[5:0];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_vector_out = rsp_vec_ff;
   assign rsp_line       = rsp_line_ff;
   assign rsp_line_bit   = rsp_bit_ff;

endmodule

`default_nettype wire
